// ----- sv/nlbt_pkg.sv -----
// ----------------------------------------------------------------------------
// Night light controller package
// Shared constants, codes, command and status types for the night light
// button and timer controller.
// ----------------------------------------------------------------------------
`default_nettype none

package nlbt_pkg;

	// Configuration register indexes and widths
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_PRESS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STARS_MIN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MOON_MIN    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_MAN   = 3'd4;

	localparam logic [15:0] SHORT_PRESS_RST = 16'd1000;
	localparam logic [15:0] LONG_PRESS_RST  = 16'd3000;
	localparam logic [9:0]  STARS_MIN_RST   = 10'd30;
	localparam logic [9:0]  MOON_MIN_RST    = 10'd30;

	// Item opcodes
	localparam logic [2:0] OP_TICK        = 3'd0;
	localparam logic [2:0] OP_MOON_START  = 3'd1;
	localparam logic [2:0] OP_MOON_END    = 3'd2;
	localparam logic [2:0] OP_STARS_START = 3'd3;
	localparam logic [2:0] OP_STARS_END   = 3'd4;
	localparam logic [2:0] OP_SET_PHASE   = 3'd5;

	// Press kinds reported in the result word
	localparam logic [1:0] PK_NONE  = 2'd0;
	localparam logic [1:0] PK_SHORT = 2'd1;
	localparam logic [1:0] PK_LONG  = 2'd2;

	localparam logic [7:0] PHASE_MAX = 8'd180;
	localparam int TICKS_PER_SECOND_DEF = 1000;

	// Ramp divider: (360*elapsed + duration) / (2*duration), quotient <= 180
	localparam int DIV_NUM_W = 25;
	localparam int DIV_DEN_W = 17;
	localparam int DIV_QUO_W = 8;
	localparam int DIV_SH_W  = DIV_DEN_W + DIV_QUO_W - 1;
	localparam int DIV_CNT_W = $clog2(DIV_QUO_W);

	typedef struct packed {
		logic accept;
		logic check;
		logic div_start;
		logic ramp;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic tick;
		logic need_div;
		logic div_busy;
	} dp_sts_t;

	// Minutes to seconds as 64*m - 4*m; 1000 minutes still fit in 16 bits.
	function automatic logic [15:0] min_to_sec(input logic [9:0] m);
		logic [15:0] w;
		w = {6'b0, m};
		return (w << 6) - (w << 2);
	endfunction

endpackage

`default_nettype wire

// ----- sv/nlbt_if.sv -----
// ----------------------------------------------------------------------------
// Night light controller channels
// Valid/ready channels for the command word and the status result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface nlbt_item_if;
	logic        valid;
	logic        ready;
	logic [2:0]  opcode;
	logic        button_level;
	logic [15:0] seconds;
	logic        wake;
	logic [7:0]  angle;

	modport source(output valid, output opcode, output button_level, output seconds,
		output wake, output angle, input ready);
	modport sink(input valid, input opcode, input button_level, input seconds,
		input wake, input angle, output ready);
endinterface

interface nlbt_result_if;
	logic       valid;
	logic       ready;
	logic       moon_on;
	logic       stars_on;
	logic [7:0] phase_value;
	logic       phase_changed;
	logic [1:0] press_kind;

	modport source(output valid, output moon_on, output stars_on, output phase_value,
		output phase_changed, output press_kind, input ready);
	modport sink(input valid, input moon_on, input stars_on, input phase_value,
		input phase_changed, input press_kind, output ready);
endinterface

`default_nettype wire

// ----- sv/nlbt_div.sv -----
// ----------------------------------------------------------------------------
// Night light ramp divider
// Restoring divider, one quotient bit per cycle, for the moon phase ramp.
// ----------------------------------------------------------------------------
`default_nettype none

module nlbt_div
	import nlbt_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [DIV_NUM_W-1:0] num,
	input  wire logic [DIV_DEN_W-1:0] den,
	output logic                      busy,
	output logic [DIV_QUO_W-1:0]      quo
);

	logic [DIV_NUM_W-1:0] rem_q;
	logic [DIV_SH_W-1:0]  dsh_q;
	logic [DIV_QUO_W-1:0] quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 fits;

	// The quotient is known to stay below 2^DIV_QUO_W, so the divisor starts
	// shifted up by DIV_QUO_W-1 and walks down one place per step.
	assign fits = rem_q >= DIV_NUM_W'(dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(DIV_QUO_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - DIV_CNT_W'(1);
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= {den, {(DIV_QUO_W-1){1'b0}}};
			quo_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - DIV_NUM_W'(dsh_q);
			end
			quo_q <= {quo_q[DIV_QUO_W-2:0], fits};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

// ----- sv/nlbt_dp.sv -----
// ----------------------------------------------------------------------------
// Night light datapath
// Lamp, timer, button and phase state, configuration registers, ramp divider
// and the result word register.
// ----------------------------------------------------------------------------
`default_nettype none

module nlbt_dp
	import nlbt_pkg::*;
#(
	parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire ctrl_cmd_t             cmd,
	output dp_sts_t                    sts,
	input  wire logic [2:0]            opcode,
	input  wire logic                  button_level,
	input  wire logic [15:0]           seconds,
	input  wire logic                  wake,
	input  wire logic [7:0]            angle,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output logic                       moon_on,
	output logic                       stars_on,
	output logic [7:0]                 phase_value,
	output logic                       phase_changed,
	output logic [1:0]                 press_kind
);

	localparam int SUB_W = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
	localparam logic [SUB_W-1:0] SUB_LAST = SUB_W'(TICKS_PER_SECOND - 1);

	// Configuration
	logic [15:0] short_q, long_q;
	logic [9:0]  stars_min_q, moon_min_q;
	logic        manual_q;

	// State
	logic [31:0]      ms_q, ms_d;
	logic [SUB_W-1:0] sub_q, sub_d;
	logic [15:0]      elapsed_q, elapsed_d;
	logic             last_btn_q, last_btn_d;
	logic [31:0]      press_start_q, press_start_d;
	logic             moon_lit_q, moon_lit_d;
	logic             stars_lit_q, stars_lit_d;
	logic             opening_q, opening_d;
	logic [15:0]      moon_dur_q, moon_dur_d;
	logic [15:0]      stars_dur_q, stars_dur_d;
	logic [7:0]       angle_q, angle_d;
	logic             changed_q, changed_d;
	logic [1:0]       kind_q, kind_d;

	logic [31:0] press_len;
	logic        mv_en;
	logic [7:0]  mv_ang;

	logic [DIV_NUM_W-1:0] div_num;
	logic [DIV_DEN_W-1:0] div_den;
	logic                 div_busy;
	logic [DIV_QUO_W-1:0] div_quo;
	logic [DIV_NUM_W-1:0] el_w;

	// 360*e as a sum of shifts
	assign el_w    = DIV_NUM_W'(elapsed_q);
	assign div_num = (el_w << 8) + (el_w << 6) + (el_w << 5) + (el_w << 3)
		+ DIV_NUM_W'(moon_dur_q);
	assign div_den = {moon_dur_q, 1'b0};

	nlbt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	always_comb begin
		sts.tick     = (opcode == OP_TICK);
		sts.need_div = moon_lit_q && (elapsed_q < moon_dur_q) && !manual_q;
		sts.div_busy = div_busy;
	end

	always_comb begin
		ms_d          = ms_q;
		sub_d         = sub_q;
		elapsed_d     = elapsed_q;
		last_btn_d    = last_btn_q;
		press_start_d = press_start_q;
		moon_lit_d    = moon_lit_q;
		stars_lit_d   = stars_lit_q;
		opening_d     = opening_q;
		moon_dur_d    = moon_dur_q;
		stars_dur_d   = stars_dur_q;
		angle_d       = angle_q;
		changed_d     = changed_q;
		kind_d        = kind_q;
		mv_en         = 1'b0;
		mv_ang        = '0;
		press_len     = ms_q + 32'd1 - press_start_q;

		if (cmd.accept) begin
			changed_d = 1'b0;
			kind_d    = PK_NONE;
			unique case (opcode)
				OP_TICK: begin
					ms_d = ms_q + 32'd1;
					if (sub_q >= SUB_LAST) begin
						sub_d = '0;
						if (elapsed_q != 16'hFFFF) begin
							elapsed_d = elapsed_q + 16'd1;
						end
					end else begin
						sub_d = sub_q + SUB_W'(1);
					end
					if (!last_btn_q && button_level) begin
						press_start_d = ms_q + 32'd1;
					end else if (last_btn_q && !button_level) begin
						if (press_len < {16'b0, short_q}) begin
							kind_d = PK_SHORT;
							// Light cycle: off, stars, stars and moon, moon, off.
							if (moon_lit_q && stars_lit_q) begin
								stars_dur_d = '0;
								stars_lit_d = 1'b0;
							end else if (!moon_lit_q && !stars_lit_q) begin
								stars_dur_d = min_to_sec(stars_min_q);
								stars_lit_d = 1'b1;
								elapsed_d   = '0;
								sub_d       = '0;
							end else if (stars_lit_q) begin
								moon_lit_d = 1'b1;
								moon_dur_d = min_to_sec(moon_min_q);
								opening_d  = 1'b0;
								mv_en      = 1'b1;
								mv_ang     = '0;
								elapsed_d  = '0;
								sub_d      = '0;
							end else begin
								moon_dur_d = '0;
								moon_lit_d = 1'b0;
							end
						end else if (press_len >= {16'b0, long_q}) begin
							kind_d = PK_LONG;
							mv_en  = 1'b1;
							mv_ang = (angle_q != '0) ? 8'd0 : PHASE_MAX;
						end
					end
					last_btn_d = button_level;
				end
				OP_MOON_START: begin
					moon_lit_d = 1'b1;
					moon_dur_d = seconds;
					opening_d  = wake;
					mv_en      = 1'b1;
					mv_ang     = wake ? PHASE_MAX : 8'd0;
					elapsed_d  = '0;
					sub_d      = '0;
				end
				OP_MOON_END: begin
					moon_dur_d = '0;
					moon_lit_d = 1'b0;
				end
				OP_STARS_START: begin
					stars_dur_d = seconds;
					stars_lit_d = 1'b1;
					elapsed_d   = '0;
					sub_d       = '0;
				end
				OP_STARS_END: begin
					stars_dur_d = '0;
					stars_lit_d = 1'b0;
				end
				OP_SET_PHASE: begin
					mv_en  = 1'b1;
					mv_ang = (angle > PHASE_MAX) ? PHASE_MAX : angle;
				end
				default: begin
				end
			endcase
		end else if (cmd.check) begin
			if (moon_lit_q && (elapsed_q >= moon_dur_q)) begin
				moon_dur_d = '0;
				moon_lit_d = 1'b0;
			end
			if (stars_lit_q && (elapsed_q >= stars_dur_q)) begin
				stars_dur_d = '0;
				stars_lit_d = 1'b0;
			end
		end else if (cmd.ramp) begin
			mv_en  = 1'b1;
			mv_ang = opening_q ? (PHASE_MAX - div_quo) : div_quo;
		end

		if (mv_en && (mv_ang != angle_q)) begin
			angle_d   = mv_ang;
			changed_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_q       <= SHORT_PRESS_RST;
			long_q        <= LONG_PRESS_RST;
			stars_min_q   <= STARS_MIN_RST;
			moon_min_q    <= MOON_MIN_RST;
			manual_q      <= 1'b0;
			ms_q          <= '0;
			sub_q         <= '0;
			elapsed_q     <= '0;
			last_btn_q    <= 1'b0;
			press_start_q <= '0;
			moon_lit_q    <= 1'b0;
			stars_lit_q   <= 1'b0;
			opening_q     <= 1'b0;
			moon_dur_q    <= '0;
			stars_dur_q   <= '0;
			angle_q       <= '0;
			changed_q     <= 1'b0;
			kind_q        <= PK_NONE;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_SHORT_PRESS: short_q     <= cfg_data;
					CFG_LONG_PRESS:  long_q      <= cfg_data;
					CFG_STARS_MIN:   stars_min_q <= cfg_data[9:0];
					CFG_MOON_MIN:    moon_min_q  <= cfg_data[9:0];
					CFG_PHASE_MAN:   manual_q    <= cfg_data[0];
					default: begin
					end
				endcase
			end
			ms_q          <= ms_d;
			sub_q         <= sub_d;
			elapsed_q     <= elapsed_d;
			last_btn_q    <= last_btn_d;
			press_start_q <= press_start_d;
			moon_lit_q    <= moon_lit_d;
			stars_lit_q   <= stars_lit_d;
			opening_q     <= opening_d;
			moon_dur_q    <= moon_dur_d;
			stars_dur_q   <= stars_dur_d;
			angle_q       <= angle_d;
			changed_q     <= changed_d;
			kind_q        <= kind_d;
		end
	end

	// The result word is a snapshot, so the next item may run while it waits.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			moon_on       <= moon_lit_q;
			stars_on      <= stars_lit_q;
			phase_value   <= angle_q;
			phase_changed <= changed_q;
			press_kind    <= kind_q;
		end
	end

endmodule

`default_nettype wire

// ----- sv/nlbt_ctrl.sv -----
// ----------------------------------------------------------------------------
// Night light controller sequencer
// Steps each command word through update, a lamp check for ticks, a ramp
// division when needed and result hand-off, and owns the channel handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module nlbt_ctrl
	import nlbt_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  wire logic    out_ready,
	output ctrl_cmd_t    cmd,
	input  wire dp_sts_t sts
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_CHECK = 2'd1;
	localparam logic [1:0] S_DIV   = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	logic [1:0] state_q, state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign in_ready  = (state_q == S_IDLE);
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid) begin
					state_d = sts.tick ? S_CHECK : S_DONE;
				end
			end
			S_CHECK: begin
				cmd.check     = 1'b1;
				cmd.div_start = sts.need_div;
				state_d       = sts.need_div ? S_DIV : S_DONE;
			end
			S_DIV: begin
				if (!sts.div_busy) begin
					cmd.ramp = 1'b1;
					state_d  = S_DONE;
				end
			end
			S_DONE: begin
				if (slot_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q != S_IDLE))
		else $error("accepted word did not start processing");

	a_load_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result register overwritten while still held");

	a_div_started: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> sts.div_busy)
		else $error("divider did not start");

	a_div_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && !sts.div_busy) |=> (state_q == S_DONE))
		else $error("ramp result not applied after division");

endmodule

`default_nettype wire

// ----- sv/night_light_button_timer_controller.sv -----
// ----------------------------------------------------------------------------
// Night light button and timer controller
// Moon and stars lamp control, button press timing and moon phase ramp.
// ----------------------------------------------------------------------------
// Usage: command words arrive on the item channel (tick with button level,
// start/end moon, start/end stars, set phase); every accepted word yields
// exactly one status word on the result channel with both lamp drives, the
// phase angle, a phase-changed flag and the kind of press that just ended.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data), to be
// used while the block is idle; the block itself does not enforce this.
// Sequencing: a non-tick command is accepted and then places its status in
// the result register; a tick has a lamp check in between and, when a lit
// moon needs its ramp angle, a ramp division: the ramp divider is a restoring
// divider that produces one of 8 quotient bits per cycle. One word is in work
// at a time; the next word is accepted as soon as the previous one has been
// placed in the result register.
// Reset clears all lamp, timer and button state and phase angle to zero and
// loads the configuration defaults. When the result receiver stalls, the
// held word stays unchanged and at most one more word is accepted, which
// then waits in its final step until the register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module night_light_button_timer_controller
	import nlbt_pkg::*;
#(
	parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	nlbt_item_if.sink                  item,
	nlbt_result_if.source              result,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	ctrl_cmd_t cmd;
	dp_sts_t   sts;
	logic      in_ready;
	logic      out_valid;

	nlbt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (result.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	nlbt_dp #(
		.TICKS_PER_SECOND (TICKS_PER_SECOND)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.opcode        (item.opcode),
		.button_level  (item.button_level),
		.seconds       (item.seconds),
		.wake          (item.wake),
		.angle         (item.angle),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.moon_on       (result.moon_on),
		.stars_on      (result.stars_on),
		.phase_value   (result.phase_value),
		.phase_changed (result.phase_changed),
		.press_kind    (result.press_kind)
	);

	assign item.ready   = in_ready;
	assign result.valid = out_valid;

endmodule

`default_nettype wire

// ----- dv/nlbt_status_checker.sv -----
// ----------------------------------------------------------------------------
// Night light controller status checker
// Watches the command, status and configuration traffic of the night light
// controller. It keeps its own copy of the lamp, timer, button and phase
// state, works out the status word that every accepted command must produce
// and compares each returned word with the oldest one still due.
// ----------------------------------------------------------------------------
module nlbt_status_checker
	import nlbt_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	nlbt_item_if                       item,
	nlbt_result_if                     result,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output int                         mismatches,
	output int                         pending,
	output int                         words_checked
);

	typedef struct packed {
		logic       moon_on;
		logic       stars_on;
		logic [7:0] phase_value;
		logic       phase_changed;
		logic [1:0] press_kind;
	} status_t;

	// Register copies
	logic [15:0] short_ms;
	logic [15:0] long_ms;
	logic [9:0]  stars_min;
	logic [9:0]  moon_min;
	logic        manual;

	// Lamp, timer and button state
	logic        moon_lit;
	logic        stars_lit;
	logic        opening;
	logic [7:0]  angle_now;
	logic        angle_moved;
	logic [15:0] moon_secs;
	logic [15:0] stars_secs;
	logic [15:0] elapsed;
	logic [9:0]  subsec;
	logic [31:0] ms_count;
	logic [31:0] press_start;
	logic        btn_prev;

	status_t status_due[$];

	function automatic void set_angle(input logic [7:0] a);
		logic [7:0] sat;
		sat = (a > PHASE_MAX) ? PHASE_MAX : a;
		if (sat != angle_now) begin
			angle_now   = sat;
			angle_moved = 1'b1;
		end
	endfunction

	function automatic void light_moon(input logic [15:0] secs, input logic wk);
		moon_lit  = 1'b1;
		moon_secs = secs;
		opening   = wk;
		set_angle(wk ? PHASE_MAX : 8'd0);
		elapsed   = '0;
		subsec    = '0;
	endfunction

	function automatic void light_stars(input logic [15:0] secs);
		stars_secs = secs;
		stars_lit  = 1'b1;
		elapsed    = '0;
		subsec     = '0;
	endfunction

	function automatic void moon_off();
		moon_secs = '0;
		moon_lit  = 1'b0;
	endfunction

	function automatic void stars_off();
		stars_secs = '0;
		stars_lit  = 1'b0;
	endfunction

	function automatic status_t next_status(input logic [2:0] op, input logic lvl,
		input logic [15:0] secs, input logic wk, input logic [7:0] ang);
		status_t     s;
		logic [1:0]  kind;
		logic [31:0] held;
		logic [31:0] ramp;
		kind        = PK_NONE;
		angle_moved = 1'b0;
		case (op)
			OP_TICK: begin
				ms_count = ms_count + 32'd1;
				subsec   = subsec + 10'd1;
				if (subsec >= TICKS_PER_SECOND_DEF) begin
					subsec = '0;
					if (elapsed != 16'hFFFF)
						elapsed = elapsed + 16'd1;
				end
				if (!btn_prev && lvl) begin
					press_start = ms_count;
				end else if (btn_prev && !lvl) begin
					held = ms_count - press_start;
					// The short test wins when the thresholds overlap.
					if (held < short_ms) begin
						kind = PK_SHORT;
						if (moon_lit && stars_lit)
							stars_off();
						else if (!moon_lit && !stars_lit)
							light_stars({6'b0, stars_min} * 16'd60);
						else if (stars_lit)
							light_moon({6'b0, moon_min} * 16'd60, 1'b0);
						else
							moon_off();
					end else if (held >= long_ms) begin
						kind = PK_LONG;
						set_angle(angle_now != 8'd0 ? 8'd0 : PHASE_MAX);
					end
				end
				btn_prev = lvl;
				if (moon_lit) begin
					if (elapsed >= moon_secs) begin
						moon_off();
					end else if (!manual) begin
						// Rounded half up; the wake direction mirrors the angle.
						ramp = (32'd360 * elapsed + moon_secs) / (32'd2 * moon_secs);
						set_angle(opening ? PHASE_MAX - ramp[7:0] : ramp[7:0]);
					end
				end
				if (stars_lit && elapsed >= stars_secs)
					stars_off();
			end
			OP_MOON_START:  light_moon(secs, wk);
			OP_MOON_END:    moon_off();
			OP_STARS_START: light_stars(secs);
			OP_STARS_END:   stars_off();
			OP_SET_PHASE:   set_angle(ang);
			default: ;
		endcase
		s.moon_on       = moon_lit;
		s.stars_on      = stars_lit;
		s.phase_value   = angle_now;
		s.phase_changed = angle_moved;
		s.press_kind    = kind;
		return s;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		status_t want;
		status_t got;
		if (!arst_n) begin
			short_ms      = SHORT_PRESS_RST;
			long_ms       = LONG_PRESS_RST;
			stars_min     = STARS_MIN_RST;
			moon_min      = MOON_MIN_RST;
			manual        = 1'b0;
			moon_lit      = 1'b0;
			stars_lit     = 1'b0;
			opening       = 1'b0;
			angle_now     = '0;
			angle_moved   = 1'b0;
			moon_secs     = '0;
			stars_secs    = '0;
			elapsed       = '0;
			subsec        = '0;
			ms_count      = '0;
			press_start   = '0;
			btn_prev      = 1'b0;
			status_due.delete();
			mismatches    = 0;
			pending       = 0;
			words_checked = 0;
		end else begin
			if (result.valid && result.ready) begin
				got = {result.moon_on, result.stars_on, result.phase_value,
					result.phase_changed, result.press_kind};
				if (status_due.size() == 0) begin
					mismatches++;
					$display({"%0t: status word with none due: expected none, ",
						"got moon=%0b stars=%0b phase=%0d"},
						$time, got.moon_on, got.stars_on, got.phase_value);
				end else begin
					want = status_due.pop_front();
					words_checked++;
					if (got !== want) begin
						mismatches++;
						$display({"%0t: status mismatch: expected moon=%0b stars=%0b ",
							"phase=%0d changed=%0b kind=%0d, got moon=%0b stars=%0b ",
							"phase=%0d changed=%0b kind=%0d"}, $time,
							want.moon_on, want.stars_on, want.phase_value,
							want.phase_changed, want.press_kind,
							got.moon_on, got.stars_on, got.phase_value,
							got.phase_changed, got.press_kind);
					end
				end
			end
			if (item.valid && item.ready)
				status_due.push_back(next_status(item.opcode, item.button_level,
					item.seconds, item.wake, item.angle));
			if (cfg_we) begin
				case (cfg_index)
					CFG_SHORT_PRESS: short_ms  = cfg_data;
					CFG_LONG_PRESS:  long_ms   = cfg_data;
					CFG_STARS_MIN:   stars_min = cfg_data[9:0];
					CFG_MOON_MIN:    moon_min  = cfg_data[9:0];
					CFG_PHASE_MAN:   manual    = cfg_data[0];
					default: ;
				endcase
			end
			pending = status_due.size();
		end
	end

endmodule

// ----- dv/night_light_button_timer_controller_test.sv -----
// ----------------------------------------------------------------------------
// Night light controller testbench
// Drives command words into the night light controller through directed
// cases and then phases of random press, command and timed lamp traffic,
// each under its own register setting and one of four handshake patterns.
// A status checker beside the block predicts and compares every status word.
// ----------------------------------------------------------------------------
module night_light_button_timer_controller_test;
	import nlbt_pkg::*;

	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam int QUIET_LIMIT  = 4000;
	localparam int HOLD_CYCLES  = 150;
	localparam int PHASES       = 6;
	localparam int MIXED_WORDS  = 75;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int src_idle_pct;
	int rcv_stall_pct;
	bit hold_req;
	int words_sent;
	int settings_used;
	int timed_runs;
	int quiet_cycles;
	int mismatches;
	int pending;
	int words_checked;

	nlbt_item_if   item_ch();
	nlbt_result_if result_ch();

	always #1 clk = ~clk;

	night_light_button_timer_controller i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	nlbt_status_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.item          (item_ch),
		.result        (result_ch),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.pending       (pending),
		.words_checked (words_checked)
	);

	// Offers one word and returns at the falling edge after it was taken.
	task automatic send_word(input logic [2:0] op, input logic lvl, input logic [15:0] secs,
		input logic wk, input logic [7:0] ang);
		while ($urandom_range(99) < src_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid        <= 1'b1;
		item_ch.opcode       <= op;
		item_ch.button_level <= lvl;
		item_ch.seconds      <= secs;
		item_ch.wake         <= wk;
		item_ch.angle        <= ang;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic tick(input logic lvl);
		send_word(OP_TICK, lvl, 16'($urandom), 1'($urandom), 8'($urandom));
	endtask

	// A press held for the given number of milliseconds.
	task automatic press(input int hold);
		repeat (hold)
			tick(1'b1);
		tick(1'b0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
	endtask

	task automatic apply_settings(input logic [15:0] short_ms, input logic [15:0] long_ms,
		input logic [9:0] stars_min, input logic [9:0] moon_min, input logic manual);
		write_reg(CFG_SHORT_PRESS, short_ms);
		write_reg(CFG_LONG_PRESS, long_ms);
		write_reg(CFG_STARS_MIN, {6'b0, stars_min});
		write_reg(CFG_MOON_MIN, {6'b0, moon_min});
		write_reg(CFG_PHASE_MAN, {15'b0, manual});
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic settle();
		item_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4)
			@(negedge clk);
	endtask

	// Result receiver; a requested hold-off is counted here.
	initial begin
		int hold_left;
		hold_left       = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
			$display("night_light_button_timer_controller_test: errors");
			$finish;
		end
	end

	initial begin
		int short_ms;
		int run_secs;
		item_ch.valid        = 1'b0;
		item_ch.opcode       = OP_TICK;
		item_ch.button_level = 1'b0;
		item_ch.seconds      = '0;
		item_ch.wake         = 1'b0;
		item_ch.angle        = '0;
		cfg_we               = 1'b0;
		cfg_index            = CFG_SHORT_PRESS;
		cfg_data             = '0;
		arst_n               = 1'b0;
		src_idle_pct         = 0;
		rcv_stall_pct        = 0;
		hold_req             = 1'b0;
		words_sent           = 0;
		settings_used        = 0;
		timed_runs           = 0;
		quiet_cycles         = 0;
		repeat (2)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part: tight press thresholds so that short, medium and long
		// presses each take only a few ticks.
		apply_settings(16'd2, 16'd3, 10'd1, 10'd1, 1'b0);
		send_word(OP_SET_PHASE, 1'b0, 16'h0000, 1'b0, 8'd255);
		send_word(OP_SET_PHASE, 1'b1, 16'hFFFF, 1'b1, PHASE_MAX);
		send_word(OP_SET_PHASE, 1'b0, 16'h0000, 1'b0, 8'd0);
		send_word(OP_SPARE_6, 1'b1, 16'hFFFF, 1'b1, 8'hFF);
		send_word(OP_STARS_START, 1'b0, 16'd0, 1'b0, 8'd0);
		tick(1'b0);
		send_word(OP_MOON_START, 1'b0, 16'hFFFF, 1'b1, 8'd0);
		tick(1'b0);
		send_word(OP_MOON_END, 1'b1, 16'hFFFF, 1'b1, 8'hFF);
		send_word(OP_STARS_END, 1'b1, 16'hFFFF, 1'b1, 8'hFF);
		repeat (4)
			press(1);
		press(2);
		press(3);
		settle();

		for (int p = 0; p < PHASES; p++) begin
			case (p % 4)
				0: begin src_idle_pct = 0;  rcv_stall_pct = 0;  end
				1: begin src_idle_pct = 60; rcv_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  rcv_stall_pct = 60; end
				default: begin src_idle_pct = 23; rcv_stall_pct = 23; end
			endcase
			case (p)
				0: apply_settings(16'd0, 16'd0, 10'd0, 10'd0, 1'b0);
				1: apply_settings(16'hFFFF, 16'hFFFF, 10'd1000, 10'd1000, 1'b1);
				5: apply_settings(SHORT_PRESS_RST, LONG_PRESS_RST, STARS_MIN_RST,
					MOON_MIN_RST, 1'b0);
				default: begin
					short_ms = $urandom_range(1, 40);
					apply_settings(16'(short_ms), 16'(short_ms + $urandom_range(80)),
						10'($urandom_range(2)), 10'($urandom_range(2)), p == 3);
				end
			endcase
			if (p == 0)
				hold_req = 1'b1;

			run_secs = words_sent;
			while (words_sent - run_secs < MIXED_WORDS) begin
				case ($urandom_range(9))
					0, 1, 2, 3: begin
						repeat ($urandom_range(3))
							tick(1'b0);
						press($urandom_range(9) < 7 ? $urandom_range(1, 40)
							: $urandom_range(41, 130));
					end
					4, 5: send_word(3'($urandom_range(7)), 1'($urandom), 16'($urandom),
						1'($urandom), 8'($urandom));
					6: send_word(OP_MOON_START, 1'($urandom), 16'($urandom_range(4)),
						1'($urandom), 8'($urandom));
					7: send_word(OP_STARS_START, 1'($urandom), 16'($urandom_range(4)),
						1'($urandom), 8'($urandom));
					8: send_word(OP_SET_PHASE, 1'($urandom), 16'($urandom), 1'($urandom),
						8'($urandom));
					default: repeat ($urandom_range(1, 20))
						tick(1'($urandom_range(9) == 0));
				endcase
			end

			// The ramp only moves once whole seconds of ticks have passed.
			if (p == 2) begin
				tick(1'b0);
				run_secs = 2;
				send_word(OP_MOON_START, 1'b0, 16'(run_secs), 1'($urandom), 8'($urandom));
				send_word(OP_STARS_START, 1'b0, 16'd1, 1'($urandom), 8'($urandom));
				repeat (TICKS_PER_SECOND_DEF * (run_secs - 1) + 5)
					tick(1'b0);
				timed_runs++;
			end
			settle();
		end

		$display("Checked %0d status words for %0d commands under %0d register settings,",
			words_checked, words_sent, settings_used);
		$display("with four handshake patterns, a long result stall and %0d timed lamp runs.",
			timed_runs);
		if (mismatches == 0 && pending == 0)
			$display("night_light_button_timer_controller_test: clean");
		else
			$display("night_light_button_timer_controller_test: errors");
		$finish;
	end

endmodule
